@@ hdl/scc_pkg.sv @@
// Package: shared types and constants for the SCC counter.
`timescale 1ns / 1ps
package scc_pkg;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned NODE_W = 10;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_ADD     = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    COLOR_WHITE = 2'd0,
    COLOR_GREY  = 2'd1,
    COLOR_BLACK = 2'd2
  } color_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
  } cmd_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] scc_count;
    logic             edges_dropped;
  } res_word_t;
endpackage

@@ hdl/scc_if.sv @@
// Interfaces: valid/ready channels for commands and results.
`timescale 1ns / 1ps
interface scc_cmd_if;
  logic              valid;
  logic              ready;
  scc_pkg::cmd_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scc_res_if;
  logic              valid;
  logic              ready;
  scc_pkg::res_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/scc_counter.sv @@
// Top level: Tarjan strongly connected component counter with a sequenced walk.
`timescale 1ns / 1ps
//  channel | dir | word                               | accepted when
//  cmd     | in  | opcode, src_node, dst_node         | valid & ready
//  res     | out | scc_count, edges_dropped           | valid & ready
//  cfg     | in  | node_count (11 b)                  | cfg_we
//
// Clear: accept, then a list-head clearing pass over every node index
// (also run after reset; cmd.ready is low during it).
// Add edge: accept, list-head read, then edge and list-head writes, or the drop flag if full or out of range.
// Compute: a color-clear pass, then a scan of the node indices that follows the stored
// edges and visits and pops the nodes; the pace is set by the one registered RAM read
// per step in the walk sequencer.
// Results sit in an output register; the next command is taken only once it
// has been delivered.  Reset is synchronous, active high.
module scc_counter #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 65536
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [scc_pkg::CNT_W-1:0]      cfg_data,
  scc_cmd_if.sink                        cmd,
  scc_res_if.source                      res
);
  localparam int unsigned NA = $clog2(MAX_NODES);
  localparam int unsigned EA = $clog2(MAX_EDGES);
  localparam int unsigned LW = EA + 1;   // link = index+1, 0 = end
  localparam int unsigned NC = NA + 1;   // node count width

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_ADD_RD, S_ADD_WR, S_C_INIT, S_ROOT, S_ROOT_RD,
    S_ENTER, S_TOP, S_TOP_RD, S_EDGE, S_EDGE_RD, S_K_RD, S_K_CHK,
    S_LOW_RD, S_LOW_UPD, S_DONE_RD, S_POP, S_POP_RD, S_RET, S_RET_RD,
    S_RET_UPD, S_RES
  } state_t;
  typedef scc_pkg::cmd_word_t cmd_word_latch_t;
  typedef logic [scc_pkg::CNT_W-1:0] CNT_W_t;

  state_t state;
  logic [10:0] node_count;
  logic [NC-1:0] n_used;
  logic [EA:0] edge_total;
  logic overflow;
  logic [NA:0] sweep;
  logic [NA:0] root, ns_top, cs_top;
  logic [NA-1:0] v, k, order;
  logic [LW-1:0] link;
  logic [NA-1:0] lv;
  logic [NC-1:0] found;
  cmd_word_latch_t cmd_q;

  // RAM ports
  logic hd_we; logic [NA-1:0] hd_wa, hd_ra; logic [LW-1:0] hd_wd, hd_rd;
  logic en_we; logic [EA-1:0] en_wa, en_ra; logic [LW-1:0] en_wd, en_rd;
  logic et_we; logic [NA-1:0] et_wd, et_rd;
  logic col_we; logic [NA-1:0] col_wa, col_ra; logic [1:0] col_wd, col_rd;
  logic vo_we; logic [NA-1:0] vo_wa, vo_ra, vo_wd, vo_rd;
  logic ll_we; logic [NA-1:0] ll_wa, ll_ra, ll_wd, ll_rd;
  logic ns_we; logic [NA-1:0] ns_wa, ns_ra, ns_wd, ns_rd;
  logic cs_we; logic [NA-1:0] cs_wa, cs_ra; logic [NA+LW-1:0] cs_wd, cs_rd;

  scc_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_head (.clk, .we(hd_we), .waddr(hd_wa),
    .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
  scc_ram #(.WIDTH(LW), .DEPTH(MAX_EDGES)) u_enext (.clk, .we(en_we), .waddr(en_wa),
    .wdata(en_wd), .raddr(en_ra), .rdata(en_rd));
  scc_ram #(.WIDTH(NA), .DEPTH(MAX_EDGES)) u_etgt (.clk, .we(et_we), .waddr(en_wa),
    .wdata(et_wd), .raddr(en_ra), .rdata(et_rd));
  scc_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_color (.clk, .we(col_we), .waddr(col_wa),
    .wdata(col_wd), .raddr(col_ra), .rdata(col_rd));
  scc_ram #(.WIDTH(NA), .DEPTH(MAX_NODES)) u_order (.clk, .we(vo_we), .waddr(vo_wa),
    .wdata(vo_wd), .raddr(vo_ra), .rdata(vo_rd));
  scc_ram #(.WIDTH(NA), .DEPTH(MAX_NODES)) u_low (.clk, .we(ll_we), .waddr(ll_wa),
    .wdata(ll_wd), .raddr(ll_ra), .rdata(ll_rd));
  scc_ram #(.WIDTH(NA), .DEPTH(MAX_NODES)) u_nstk (.clk, .we(ns_we), .waddr(ns_wa),
    .wdata(ns_wd), .raddr(ns_ra), .rdata(ns_rd));
  scc_ram #(.WIDTH(NA+LW), .DEPTH(MAX_NODES)) u_cstk (.clk, .we(cs_we), .waddr(cs_wa),
    .wdata(cs_wd), .raddr(cs_ra), .rdata(cs_rd));

  // node count in use, clamped to MAX_NODES
  always_comb begin
    if ({1'b0, node_count} > 12'(MAX_NODES)) begin
      n_used = NC'(MAX_NODES);
    end else begin
      n_used = NC'(node_count);
    end
  end

  logic [NA-1:0] cs_v;
  logic [LW-1:0] cs_l;
  assign cs_v = cs_rd[NA+LW-1:LW];
  assign cs_l = cs_rd[LW-1:0];

  logic add_bad;
  assign add_bad = (edge_total >= (EA+1)'(MAX_EDGES)) ||
                   ({2'b0, cmd_q.src_node} >= 12'(n_used)) ||
                   ({2'b0, cmd_q.dst_node} >= 12'(n_used));

  logic link_ok;
  assign link_ok = (cs_l != '0) && ({1'b0, cs_l} <= (LW+1)'(MAX_EDGES));

  // RAM control, decoded from the state, with some writes gated by a compare
  always_comb begin
    hd_we = 1'b0; hd_wa = sweep[NA-1:0]; hd_wd = '0; hd_ra = root[NA-1:0];
    en_we = 1'b0; et_we = 1'b0; en_wa = edge_total[EA-1:0];
    en_wd = hd_rd; et_wd = cmd_q.dst_node[NA-1:0];
    en_ra = EA'(link - 1'b1);
    col_we = 1'b0; col_wa = sweep[NA-1:0]; col_wd = scc_pkg::COLOR_WHITE;
    col_ra = k;
    vo_we = 1'b0; vo_wa = v; vo_wd = order; vo_ra = v;
    ll_we = 1'b0; ll_wa = v; ll_wd = order; ll_ra = k;
    ns_we = 1'b0; ns_wa = ns_top[NA-1:0]; ns_wd = v;
    ns_ra = NA'(ns_top - 1'b1);
    cs_we = 1'b0; cs_wa = NA'(cs_top - 1'b1); cs_wd = {v, link};
    cs_ra = NA'(cs_top - 1'b1);
    unique case (state)
      S_INIT: begin
        hd_we = 1'b1;
      end
      S_ADD_RD: hd_ra = cmd_q.src_node[NA-1:0];
      S_ADD_WR: begin
        if (!add_bad) begin
          en_we = 1'b1; et_we = 1'b1;
          hd_we = 1'b1; hd_wa = cmd_q.src_node[NA-1:0];
          hd_wd = LW'(edge_total) + 1'b1;
        end
      end
      S_C_INIT: col_we = 1'b1;
      S_ROOT: col_ra = root[NA-1:0];
      S_ENTER: begin
        // v holds the new node, hd_rd its list head
        vo_we = 1'b1; ll_we = 1'b1;
        col_we = 1'b1; col_wa = v; col_wd = scc_pkg::COLOR_GREY;
        ns_we = 1'b1;
        cs_we = 1'b1; cs_wa = cs_top[NA-1:0]; cs_wd = {v, hd_rd};
      end
      S_TOP: ;
      S_TOP_RD: begin
        vo_ra = cs_v; ll_ra = cs_v;
      end
      S_EDGE: ;
      S_EDGE_RD: begin
        cs_we = 1'b1; cs_wd = {v, en_rd};
        col_ra = et_rd; hd_ra = et_rd;
      end
      // keep the head of k on the read port in case k is entered next
      S_K_RD: begin
        ll_ra = k; hd_ra = k;
      end
      S_LOW_RD: ll_ra = v;
      // lv = low[k], ll_rd = low[v]
      S_LOW_UPD: begin
        if (lv < ll_rd) begin
          ll_we = 1'b1; ll_wd = lv;
        end
      end
      S_POP: ;
      S_POP_RD: begin
        col_we = 1'b1; col_wa = ns_rd; col_wd = scc_pkg::COLOR_BLACK;
      end
      // parent frame sits just below the frame being dropped
      S_RET: begin
        col_ra = v;
        cs_ra = NA'(cs_top - 2'd2);
      end
      S_RET_RD: ll_ra = cs_v;
      S_RET_UPD: begin
        if (lv < ll_rd) begin
          ll_we = 1'b1; ll_wa = k; ll_wd = lv;
        end
      end
      default: ;
    endcase
  end

  assign cmd.ready = (state == S_IDLE) && !res.valid;
  assign res.data.scc_count = CNT_W_t'(found);
  assign res.data.edges_dropped = overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; sweep <= '0; node_count <= 11'd1;
      edge_total <= '0; overflow <= 1'b0; res.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == (NA+1)'(MAX_NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid && cmd.ready) begin
            cmd_q <= cmd.data;
            unique case (cmd.data.opcode)
              scc_pkg::OP_CLEAR: begin
                edge_total <= '0; overflow <= 1'b0; sweep <= '0;
                state <= S_INIT;
              end
              scc_pkg::OP_ADD: state <= S_ADD_RD;
              scc_pkg::OP_COMPUTE: begin
                sweep <= '0; state <= S_C_INIT;
              end
              default: ;
            endcase
          end
        end
        S_ADD_RD: state <= S_ADD_WR;
        S_ADD_WR: begin
          if (add_bad) begin
            overflow <= 1'b1;
          end else begin
            edge_total <= edge_total + 1'b1;
          end
          state <= S_IDLE;
        end
        S_C_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == (NA+1)'(MAX_NODES - 1)) begin
            root <= '0; order <= '0; ns_top <= '0; cs_top <= '0; found <= '0;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if ({1'b0, root} >= (NA+2)'(n_used)) begin
            state <= S_RES;
          end else begin
            state <= S_ROOT_RD;
          end
        end
        S_ROOT_RD: begin
          if (col_rd != scc_pkg::COLOR_WHITE) begin
            root <= root + 1'b1;
            state <= S_ROOT;
          end else begin
            v <= root[NA-1:0];
            state <= S_ENTER;
          end
        end
        S_ENTER: begin
          order <= order + 1'b1;
          ns_top <= ns_top + 1'b1;
          cs_top <= cs_top + 1'b1;
          state <= S_TOP;
        end
        S_TOP: begin
          if (cs_top == '0) begin
            root <= root + 1'b1;
            state <= S_ROOT;
          end else begin
            state <= S_TOP_RD;
          end
        end
        S_TOP_RD: begin
          v <= cs_v; link <= cs_l;
          state <= link_ok ? S_EDGE : S_DONE_RD;
        end
        S_EDGE: state <= S_EDGE_RD;
        S_EDGE_RD: begin
          k <= et_rd;
          if ({1'b0, et_rd} >= (NA+1)'(n_used)) begin
            state <= S_TOP;
          end else begin
            state <= S_K_RD;
          end
        end
        S_K_RD: begin
          if (col_rd == scc_pkg::COLOR_WHITE) begin
            v <= k;
            state <= S_ENTER;
          end else if (col_rd == scc_pkg::COLOR_GREY) begin
            state <= S_LOW_RD;
          end else begin
            state <= S_TOP;
          end
        end
        S_LOW_RD: begin
          lv <= ll_rd;
          state <= S_LOW_UPD;
        end
        S_LOW_UPD: state <= S_TOP;
        S_DONE_RD: begin
          lv <= ll_rd;
          if (vo_rd == ll_rd) begin
            found <= found + 1'b1;
            state <= S_POP;
          end else begin
            state <= S_RET;
          end
        end
        S_POP: state <= (ns_top == '0) ? S_RET : S_POP_RD;
        S_POP_RD: begin
          ns_top <= ns_top - 1'b1;
          state <= (ns_rd == v) ? S_RET : S_POP;
        end
        S_RET: begin
          cs_top <= cs_top - 1'b1;
          state <= S_RET_RD;
        end
        S_RET_RD: begin
          k <= cs_v;
          if (cs_top != '0 && col_rd == scc_pkg::COLOR_GREY) begin
            state <= S_RET_UPD;
          end else begin
            state <= S_TOP;
          end
        end
        S_RET_UPD: state <= S_TOP;
        S_RES: begin
          res.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd.ready) else $error("cmd taken while busy");
  a_res_idle: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (state == S_IDLE)) else $error("result word while busy");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> res.valid) else $error("result lost");
endmodule

@@ hdl/scc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module scc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ tb/scc_counter_tb.sv @@
// Testbench: drives commands into scc_counter and checks each component count and dropped flag.
`timescale 1ns / 1ps

// Scoreboard: tracks the graph as it is loaded and predicts each compute word.
class scc_scoreboard;
  int unsigned node_lim;                  // node_count register as written
  int unsigned head_of [1024];            // list heads, link = index+1, 0 ends
  int unsigned nxt [$];
  int unsigned tgt [$];
  bit dropped;
  scc_pkg::res_word_t pending [$];
  int unsigned errors;

  function new();
    node_lim = 1;
    errors = 0;
    wipe();
  endfunction

  function void wipe();
    foreach (head_of[i]) head_of[i] = 0;
    nxt.delete();
    tgt.delete();
    dropped = 0;
  endfunction

  function int unsigned live_nodes();
    return (node_lim > 1024) ? 1024 : node_lim;
  endfunction

  // Iterative Tarjan walk; counts component roots.
  function int unsigned tarjan_count();
    int unsigned n, order, found, ns_top, cs_top, v, lnk, k, w, p, r;
    int unsigned color [1024];
    int unsigned vord [1024];
    int unsigned low [1024];
    int unsigned nstk [1024];
    int unsigned cnode [1024];
    int unsigned clink [1024];
    n = live_nodes();
    order = 0; found = 0; ns_top = 0; cs_top = 0;
    foreach (color[i]) color[i] = scc_pkg::COLOR_WHITE;
    for (r = 0; r < n; r++) begin
      if (color[r] != scc_pkg::COLOR_WHITE) continue;
      vord[r] = order; low[r] = order; order++;
      color[r] = scc_pkg::COLOR_GREY;
      nstk[ns_top++] = r;
      cnode[cs_top] = r; clink[cs_top] = head_of[r]; cs_top++;
      while (cs_top > 0) begin
        v = cnode[cs_top-1];
        lnk = clink[cs_top-1];
        if (lnk != 0) begin
          k = tgt[lnk-1];
          clink[cs_top-1] = nxt[lnk-1];
          if (k >= n) continue;
          if (color[k] == scc_pkg::COLOR_WHITE) begin
            vord[k] = order; low[k] = order; order++;
            color[k] = scc_pkg::COLOR_GREY;
            nstk[ns_top++] = k;
            cnode[cs_top] = k; clink[cs_top] = head_of[k]; cs_top++;
          end else if (color[k] == scc_pkg::COLOR_GREY) begin
            if (low[k] < low[v]) low[v] = low[k];
          end
          continue;
        end
        if (vord[v] == low[v]) begin
          found++;
          do begin
            if (ns_top == 0) break;
            w = nstk[--ns_top];
            color[w] = scc_pkg::COLOR_BLACK;
          end while (w != v);
        end
        cs_top--;
        if (cs_top > 0 && color[v] == scc_pkg::COLOR_GREY) begin
          p = cnode[cs_top-1];
          if (low[v] < low[p]) low[p] = low[v];
        end
      end
    end
    return found;
  endfunction

  // Note one accepted command word.
  function void note_cmd(scc_pkg::cmd_word_t c);
    scc_pkg::res_word_t r;
    int unsigned n;
    n = live_nodes();
    case (c.opcode)
      scc_pkg::OP_CLEAR: wipe();
      scc_pkg::OP_ADD: begin
        if (tgt.size() >= 65536 || c.src_node >= n || c.dst_node >= n) begin
          dropped = 1;
        end else begin
          tgt.push_back(c.dst_node);
          nxt.push_back(head_of[c.src_node]);
          head_of[c.src_node] = tgt.size();
        end
      end
      scc_pkg::OP_COMPUTE: begin
        r.scc_count = scc_pkg::CNT_W'(tarjan_count());
        r.edges_dropped = dropped;
        pending.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Check one accepted result word against the oldest prediction.
  function void check_res(scc_pkg::res_word_t got);
    scc_pkg::res_word_t exp_w;
    if (pending.size() == 0) begin
      $error("unexpected result word scc_count=%0d", got.scc_count);
      errors++;
      return;
    end
    exp_w = pending.pop_front();
    if (got.scc_count !== exp_w.scc_count) begin
      $error("scc_count expected %0d actual %0d", exp_w.scc_count, got.scc_count);
      errors++;
    end
    if (got.edges_dropped !== exp_w.edges_dropped) begin
      $error("edges_dropped expected %0d actual %0d", exp_w.edges_dropped,
             got.edges_dropped);
      errors++;
    end
  endfunction
endclass

module scc_counter_tb;
  localparam int unsigned IDLE_LIMIT = 200000;  // watchdog bound on idle clocks, sized for a compute of 1024 nodes
  localparam int unsigned SETTLE     = 3000;    // covers a clear's head-wipe pass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [scc_pkg::CNT_W-1:0] cfg_data = '0;

  scc_cmd_if cmd ();
  scc_res_if res ();

  scc_counter dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd.sink),
    .res      (res.source)
  );

  always #1 clk = ~clk;

  scc_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  bit hold_res = 0;        // long receiver hold-off, set by the stimulus
  bit busy_stall = 1;      // random stalls on result ready

  initial begin
    cmd.valid = 0;
    cmd.data = '0;
    res.ready = 0;
  end

  // Sample at the rising edge: score accepted words, run the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd.valid && cmd.ready) sb.note_cmd(cmd.data);
      if (res.valid && res.ready) sb.check_res(res.data);
      if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: its own stall pattern, plus the long hold-off.
  always @(negedge clk) begin
    if (rst || hold_res) res.ready <= 0;
    else if (!busy_stall) res.ready <= 1;
    else res.ready <= ($urandom_range(0, 3) != 0);
  end

  // Sender gap state: bursts of random length, random gaps between.
  int unsigned burst_left = 0;

  // Offer one word; hold it until accepted. Valid drops only for a gap.
  task automatic send_word(scc_pkg::cmd_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        cmd.valid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    cmd.data <= w;
    cmd.valid <= 1;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_op(scc_pkg::opcode_t op, int unsigned s, int unsigned d);
    scc_pkg::cmd_word_t w;
    w.opcode = op;
    w.src_node = scc_pkg::NODE_W'(s);
    w.dst_node = scc_pkg::NODE_W'(d);
    send_word(w);
  endtask

  // Write node_count only with the block idle.
  task automatic set_nodes(int unsigned n);
    cmd.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_data <= scc_pkg::CNT_W'(n);
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    sb.node_lim = n;
  endtask

  // A random graph on n nodes: mostly valid edges, some out of range, with unused opcodes and extra computes
  task automatic random_graph(int unsigned n, int unsigned edges);
    int unsigned s, d;
    send_op(scc_pkg::OP_CLEAR, $urandom, $urandom);
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        s = $urandom_range(0, 1023);
        d = $urandom_range(0, 1023);
      end else begin
        s = $urandom_range(0, n - 1);
        d = $urandom_range(0, n - 1);
      end
      if ($urandom_range(0, 49) == 0) send_op(scc_pkg::OP_NONE, $urandom, $urandom);
      else send_op(scc_pkg::OP_ADD, s, d);
      if ($urandom_range(0, 15) == 0) send_op(scc_pkg::OP_COMPUTE, 0, 0);
    end
    send_op(scc_pkg::OP_COMPUTE, 0, 0);
  endtask

  initial begin
    int unsigned n;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: reset node count of 1, self loop, extremes, unused opcode.
    send_op(scc_pkg::OP_COMPUTE, 0, 0);
    send_op(scc_pkg::OP_ADD, 0, 0);
    send_op(scc_pkg::OP_ADD, 1023, 0);
    send_op(scc_pkg::OP_NONE, 1023, 1023);
    send_op(scc_pkg::OP_COMPUTE, 0, 0);
    set_nodes(4);
    send_op(scc_pkg::OP_CLEAR, 1023, 1023);
    send_op(scc_pkg::OP_ADD, 0, 1);
    send_op(scc_pkg::OP_ADD, 1, 2);
    send_op(scc_pkg::OP_ADD, 2, 0);
    send_op(scc_pkg::OP_ADD, 2, 3);
    send_op(scc_pkg::OP_ADD, 3, 3);
    send_op(scc_pkg::OP_COMPUTE, 0, 0);
    // lowering the count leaves edges to dropped nodes in the store
    set_nodes(2);
    send_op(scc_pkg::OP_COMPUTE, 0, 0);
    set_nodes(0);                       // count of zero
    send_op(scc_pkg::OP_COMPUTE, 0, 0);
    send_op(scc_pkg::OP_ADD, 0, 0);
    set_nodes(2047);                    // above MAX_NODES, clamps to 1024
    send_op(scc_pkg::OP_CLEAR, 0, 0);
    send_op(scc_pkg::OP_ADD, 1023, 0);
    send_op(scc_pkg::OP_ADD, 0, 1023);
    send_op(scc_pkg::OP_ADD, 682, 341);
    send_op(scc_pkg::OP_COMPUTE, 0, 0);
    set_nodes(1024);
    send_op(scc_pkg::OP_COMPUTE, 0, 0);

    // Long receiver hold-off while commands keep coming; outlasts the compute.
    set_nodes(8);
    hold_res = 1;
    fork
      begin
        repeat (4000) @(negedge clk);
        hold_res = 0;
      end
      begin
        send_op(scc_pkg::OP_COMPUTE, 0, 0);
        send_op(scc_pkg::OP_ADD, 1, 2);
        send_op(scc_pkg::OP_COMPUTE, 0, 0);
      end
    join

    // Random phases: mostly small graphs, a few large, and single-node ones.
    for (int ph = 0; ph < 34; ph++) begin
      case (ph % 10)
        9: n = $urandom_range(900, 1024);
        4: n = 1;
        default: n = $urandom_range(2, 24);
      endcase
      set_nodes(n);
      busy_stall = (ph % 4 != 3);
      random_graph(n, (n > 100) ? $urandom_range(20, 60) : $urandom_range(10, 60));
    end

    cmd.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
